// ----- rtl/lsv_pkg.sv -----
// ----------------------------------------------------------------------------
// lsv_pkg
// shared widths, defaults and controller/datapath handshake types for the
// luby sequence value core
// ----------------------------------------------------------------------------
package lsv_pkg;

    localparam int INDEX_W        = 32;   // width of the index field
    localparam int TERM_W         = 32;   // width of the term field
    localparam int INDEX_BITS_DEF = 32;   // default working width of the index

    // controller to datapath
    typedef struct packed {
        logic load;       // take a new index
        logic step;       // one reduction round
        logic load_out;   // capture the finished term into the output register
    } lsv_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;        // term is known (power of two reached or zero index)
    } lsv_sts_t;

endpackage

// ----- rtl/lsv_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsv_ctrl
// sequencing controller: accepts an index, runs reduction rounds until the
// datapath reports a hit, then hands the term to the output register
// ----------------------------------------------------------------------------
module lsv_ctrl
    import lsv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  lsv_sts_t sts,
    output lsv_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (sts.hit)
                begin
                    // wait here while a previous result is still unread
                    if (out_free)
                    begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/lsv_dp.sv -----
// ----------------------------------------------------------------------------
// lsv_dp
// reduction datapath: holds target = index+1 and a one-hot probe that walks
// down from the top bit, plus the output register
// ----------------------------------------------------------------------------
module lsv_dp
    import lsv_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic               clk,
    input  logic [INDEX_W-1:0] index,
    input  lsv_cmd_t           cmd,
    output lsv_sts_t           sts,
    output logic [TERM_W-1:0]  term,
    output logic               invalid
);

    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS:0]   x_reg;
    logic [INDEX_BITS:0]   x_next;
    logic [INDEX_BITS:0]   top_reg;
    logic [INDEX_BITS:0]   top_next;
    logic                  zero_reg;
    logic                  zero_next;
    logic [TERM_W-1:0]     term_reg;
    logic [TERM_W-1:0]     term_next;
    logic                  invalid_reg;
    logic                  invalid_next;
    logic [INDEX_BITS-1:0] half;
    logic [TERM_W-1:0]     half_ext;
    logic [INDEX_BITS:0]   fold;

    // fit the index field to the working width
    generate
        if (INDEX_BITS > INDEX_W)
        begin : g_idx_wide
            assign idx = {{(INDEX_BITS - INDEX_W){1'b0}}, index};
        end
        else if (INDEX_BITS == INDEX_W)
        begin : g_idx_same
            assign idx = index;
        end
        else
        begin : g_idx_narrow
            assign idx = index[INDEX_BITS-1:0];
        end
    endgenerate

    // term is half the probe once the probe equals the target
    assign half = top_reg[INDEX_BITS:1];

    generate
        if (INDEX_BITS > TERM_W)
        begin : g_term_wide
            assign half_ext = half[TERM_W-1:0];
        end
        else if (INDEX_BITS == TERM_W)
        begin : g_term_same
            assign half_ext = half;
        end
        else
        begin : g_term_narrow
            assign half_ext = {{(TERM_W - INDEX_BITS){1'b0}}, half};
        end
    endgenerate

    // target with its leading bit dropped, plus one
    assign fold = (x_reg ^ top_reg) + {{INDEX_BITS{1'b0}}, 1'b1};

    assign sts.hit = zero_reg || (x_reg == top_reg);

    always_comb
    begin
        x_next       = x_reg;
        top_next     = top_reg;
        zero_next    = zero_reg;
        term_next    = term_reg;
        invalid_next = invalid_reg;
        if (cmd.load)
        begin
            x_next    = {1'b0, idx} + {{INDEX_BITS{1'b0}}, 1'b1};
            top_next  = {1'b1, {INDEX_BITS{1'b0}}};
            zero_next = (idx == '0);
        end
        if (cmd.step)
        begin
            top_next = top_reg >> 1;
            // probe on the leading bit: drop it and add one
            if ((x_reg & top_reg) != '0)
            begin
                x_next = fold;
                // folded onto the probe itself: hit there next cycle
                if (fold == top_reg)
                    top_next = top_reg;
            end
        end
        if (cmd.load_out)
        begin
            term_next    = zero_reg ? '0 : half_ext;
            invalid_next = zero_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        top_reg     <= top_next;
        zero_reg    <= zero_next;
        term_reg    <= term_next;
        invalid_reg <= invalid_next;
    end

    assign term    = term_reg;
    assign invalid = invalid_reg;

endmodule

// ----- rtl/luby_sequence_value_core.sv -----
// ----------------------------------------------------------------------------
// luby_sequence_value_core
// luby restart sequence term for a 1-based index (1,1,2,1,1,2,4,...)
// ----------------------------------------------------------------------------
// sequence: a zero index is handed off with no reduction round; otherwise one
//   reduction round per bit the probe walks down from the top of index+1,
//   then the output is loaded once any previous result is taken or being taken
// throughput: one item at a time; s_tready returns the cycle after the term
//   is loaded into the output register, which holds it until taken
// reset: rst_n asynchronous active low clears the controller and output valid
// ----------------------------------------------------------------------------
module luby_sequence_value_core
    import lsv_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] index
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] term
    output logic        m_tuser    // [0] invalid (index was zero)
);

    lsv_cmd_t cmd;
    lsv_sts_t sts;

    // sequencing: idle -> run rounds -> hand off term
    lsv_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // target register, walking probe and output register
    lsv_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp
    (
        .clk     (clk),
        .index   (s_tdata),
        .cmd     (cmd),
        .sts     (sts),
        .term    (m_tdata),
        .invalid (m_tuser)
    );

    // a term is handed off only once it is known
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.hit)
        else $error("output loaded before the term was found");

    // a round and a hand-off never happen together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.step && cmd.load_out))
        else $error("reduction round and output load in the same cycle");

    // a delivered term is a power of two, or zero for an invalid index
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($onehot(m_tdata) && !m_tuser) || (m_tdata == '0 && m_tuser))
        else $error("term is not a power of two or invalid flag mismatch");

    // the input is ready again in the cycle after an output load
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> s_tready)
        else $error("input not ready after output load");

endmodule
